@@ hdl/dpt_pkg.sv @@
// dpt_pkg: types, codes and table-entry helpers for the dat page table walker
// no dependencies; used by dpt_step and dat_page_table_walker_core
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

    // walk phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ROOT  = 2'd1;
    localparam logic [1:0] PH_ENTRY = 2'd2;

    // translation levels
    localparam logic [2:0] LVL_PAGE    = 3'd0;
    localparam logic [2:0] LVL_SEGMENT = 3'd1;
    localparam logic [2:0] LVL_REGION3 = 3'd2;
    localparam logic [2:0] LVL_REGION2 = 3'd3;
    localparam logic [2:0] LVL_REGION1 = 3'd4;

    // item actions and result kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_RESP  = 1'b1;
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // configuration register indexes
    localparam logic CFG_TABLE_ORIGIN = 1'b0;
    localparam logic CFG_BYTE_SWAP    = 1'b1;

    // entry bits
    localparam int unsigned REGION_INV_BIT  = 5;
    localparam int unsigned SEGMENT_INV_BIT = 5;
    localparam int unsigned PAGE_INV_BIT    = 10;
    localparam int unsigned LARGE_BIT       = 10;

    localparam logic [11:0] FULL_LEN = 12'd2048;

    typedef struct packed {
        logic        action;
        logic [63:0] start_va;
        logic [63:0] mem_data;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [63:0] mem_addr;
        logic        mapped;
        logic [63:0] phys_addr;
        logic [63:0] virt_base;
        logic [63:0] next_virt_addr;
        logic [2:0]  map_level;
    } t_out;

    typedef struct packed {
        logic [1:0]  phase;
        logic [2:0]  level;
        logic [63:0] va;
        logic [63:0] tbl;
    } t_walk;

    typedef struct packed {
        logic [63:0] table_origin;
        logic        byte_swap;
    } t_cfg;

    function automatic logic [2:0] clamp_level(input logic [2:0] lvl);
        clamp_level = (lvl > LVL_REGION1) ? LVL_REGION1 : lvl;
    endfunction

    // mask that keeps the bits at and above the level's shift
    function automatic logic [63:0] level_mask(input logic [2:0] lvl);
        logic [63:0] m;
        begin
            case (clamp_level(lvl))
                LVL_PAGE:    m = ~64'h0000_0000_0000_0fff;
                LVL_SEGMENT: m = ~64'h0000_0000_000f_ffff;
                LVL_REGION3: m = ~64'h0000_0000_7fff_ffff;
                LVL_REGION2: m = ~64'h0000_03ff_ffff_ffff;
                default:     m = ~64'h001f_ffff_ffff_ffff;
            endcase
            level_mask = m;
        end
    endfunction

    // table index of va at a level: 8 bits for pages, 11 bits above
    function automatic logic [10:0] level_index(input logic [2:0] lvl,
                                                input logic [63:0] va);
        logic [10:0] idx;
        begin
            case (clamp_level(lvl))
                LVL_PAGE:    idx = {3'b000, va[19:12]};
                LVL_SEGMENT: idx = va[30:20];
                LVL_REGION3: idx = va[41:31];
                LVL_REGION2: idx = va[52:42];
                default:     idx = va[63:53];
            endcase
            level_index = idx;
        end
    endfunction

    function automatic logic [63:0] swap64(input logic [63:0] v);
        logic [63:0] r;
        begin
            for (int i = 0; i < 8; i++) begin
                r[8*i +: 8] = v[8*(7-i) +: 8];
            end
            swap64 = r;
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/dat_page_table_walker_core.sv @@
// dat_page_table_walker_core: top level of the dat page table walker
// depends on dpt_pkg and dpt_step
`timescale 1ns / 1ps
`default_nettype none

//  channel | handshake                | payload           | direction
//  --------+--------------------------+-------------------+----------
//  in      | i_in_valid / o_in_ready  | i_in_data (t_in)  | into core
//  out     | o_out_valid / i_out_ready| o_out_data (t_out)| out of core
//  cfg     | i_cfg_we                 | i_cfg_idx, data   | into core
//
// one beat per cycle while the result channel is ready; a beat lands in the input
// register, is decoded there by dpt_step and moves to the result register on advance
// the walk state updates as each beat leaves the input register, so the next
// beat always sees the entry decode of the one before it
// i_rst_n is synchronous, active low; clears walk state, config and valids
// a stalled result register holds the input stage; responses while idle are dropped

module dat_page_table_walker_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // item channel
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire dpt_pkg::t_in   i_in_data,
    // result channel
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output dpt_pkg::t_out       o_out_data,
    // configuration writes
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [63:0]          i_cfg_data
);

    // input register
    logic            r_in_vld;
    dpt_pkg::t_in    r_in;

    // result register
    logic            r_out_vld;
    dpt_pkg::t_out   r_out;

    // walk state and config
    dpt_pkg::t_walk  r_st;
    dpt_pkg::t_walk  n_st;
    dpt_pkg::t_cfg   r_cfg;

    dpt_pkg::t_out   step_res;
    logic            step_vld;
    logic            adv;

    // the input beat moves on when the result register is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    dpt_step u_step (
        .i_cfg     (r_cfg),
        .i_st      (r_st),
        .i_item    (r_in),
        .o_st      (n_st),
        .o_res     (step_res),
        .o_res_vld (step_vld)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // walk state commits when a beat is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase <= dpt_pkg::PH_IDLE;
            r_st.level <= dpt_pkg::LVL_PAGE;
            r_st.va    <= '0;
            r_st.tbl   <= '0;
        end else if (adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_origin <= '0;
            r_cfg.byte_swap    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpt_pkg::CFG_TABLE_ORIGIN: r_cfg.table_origin <= i_cfg_data;
                dpt_pkg::CFG_BYTE_SWAP:    r_cfg.byte_swap    <= i_cfg_data[0];
                default:                   r_cfg              <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= step_vld;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && step_vld) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ hdl/dpt_step.sv @@
// dpt_step: decodes one beat against the walk state, gives next state and result
// depends on dpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpt_step (
    input  wire dpt_pkg::t_cfg  i_cfg,
    input  wire dpt_pkg::t_walk i_st,
    input  wire dpt_pkg::t_in   i_item,
    output dpt_pkg::t_walk      o_st,
    output dpt_pkg::t_out       o_res,
    output logic                o_res_vld
);

    always_comb begin
        logic [63:0] e;
        logic [2:0]  lvl;
        logic        do_desc;
        logic [2:0]  d_lvl;
        logic [63:0] d_tbl;
        logic [11:0] d_len;
        logic [10:0] d_off;
        logic [10:0] idx;
        logic [10:0] diff;
        logic        fin;
        logic [2:0]  f_lvl;
        logic        f_map;
        logic [63:0] f_phys;
        logic [63:0] m;

        o_st      = i_st;
        o_res     = '0;
        o_res_vld = 1'b0;
        e         = i_cfg.byte_swap ? dpt_pkg::swap64(i_item.mem_data) : i_item.mem_data;
        lvl       = dpt_pkg::clamp_level(i_st.level);
        do_desc   = 1'b0;
        d_lvl     = dpt_pkg::LVL_PAGE;
        d_tbl     = i_st.tbl;
        d_len     = dpt_pkg::FULL_LEN;
        d_off     = '0;
        fin       = 1'b0;
        f_lvl     = lvl;
        f_map     = 1'b0;
        f_phys    = '0;

        if (i_item.action == dpt_pkg::ACT_START) begin
            o_st.phase = dpt_pkg::PH_ROOT;
            o_st.level = dpt_pkg::LVL_PAGE;
            o_st.va    = i_item.start_va;
            o_st.tbl   = {i_cfg.table_origin[63:12], 12'h000};
            o_res_vld  = 1'b1;
            o_res.kind     = dpt_pkg::KIND_REQ;
            o_res.mem_addr = {i_cfg.table_origin[63:12], 12'h000};
        end else if (i_st.phase == dpt_pkg::PH_ROOT) begin
            // table type bits of the root entry give the starting level
            do_desc = 1'b1;
            d_lvl   = 3'd1 + {1'b0, e[3:2]};
        end else if (i_st.phase == dpt_pkg::PH_ENTRY) begin
            if (lvl >= dpt_pkg::LVL_REGION3) begin
                d_len = {({1'b0, e[1:0]} + 3'd1), 9'h000};
                d_off = {e[7:6], 9'h000};
            end
            if ((lvl == dpt_pkg::LVL_PAGE && e[dpt_pkg::PAGE_INV_BIT]) ||
                (lvl == dpt_pkg::LVL_SEGMENT && e[dpt_pkg::SEGMENT_INV_BIT]) ||
                (lvl >= dpt_pkg::LVL_REGION3 && e[dpt_pkg::REGION_INV_BIT])) begin
                fin = 1'b1;
            end else if (lvl == dpt_pkg::LVL_SEGMENT && e[dpt_pkg::LARGE_BIT]) begin
                fin    = 1'b1;
                f_map  = 1'b1;
                f_phys = {e[63:20], 20'h0};
            end else if (lvl == dpt_pkg::LVL_REGION3 && e[dpt_pkg::LARGE_BIT]) begin
                fin    = 1'b1;
                f_map  = 1'b1;
                f_phys = {e[63:31], 31'h0};
            end else if (lvl == dpt_pkg::LVL_PAGE) begin
                fin    = 1'b1;
                f_map  = 1'b1;
                f_phys = {e[63:12], 12'h000};
            end else begin
                do_desc = 1'b1;
                d_lvl   = lvl - 3'd1;
                d_tbl   = (lvl == dpt_pkg::LVL_SEGMENT) ? {e[63:11], 11'h000}
                                                        : {e[63:12], 12'h000};
            end
        end

        // descend: index the child table, or end the walk when out of range
        idx  = dpt_pkg::level_index(d_lvl, i_st.va);
        diff = idx - d_off;
        if (do_desc) begin
            o_st.level = d_lvl;
            o_st.tbl   = d_tbl;
            if (idx < d_off || {1'b0, diff} >= d_len) begin
                fin   = 1'b1;
                f_lvl = d_lvl;
            end else begin
                o_st.phase     = dpt_pkg::PH_ENTRY;
                o_res_vld      = 1'b1;
                o_res.kind     = dpt_pkg::KIND_REQ;
                o_res.mem_addr = d_tbl + {50'h0, diff, 3'b000};
            end
        end

        m = dpt_pkg::level_mask(f_lvl);
        if (fin) begin
            o_st.phase           = dpt_pkg::PH_IDLE;
            o_res_vld            = 1'b1;
            o_res.kind           = dpt_pkg::KIND_DONE;
            o_res.mapped         = f_map;
            o_res.phys_addr      = f_phys;
            o_res.virt_base      = i_st.va & m;
            o_res.next_virt_addr = (i_st.va | ~m) + 64'd1;
            o_res.map_level      = dpt_pkg::clamp_level(f_lvl);
        end
    end

endmodule

`default_nettype wire
